FILE: src/hctb_pkg.sv
// Package for the Huffman code table builder: transaction types, opcodes and
// default sizes. Used by the top level; no dependencies.
`timescale 1ns / 1ps
package hctb_pkg;

    // Defaults for the top-level parameters.
    localparam int ALPHABET_DEF     = 256;
    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int WEIGHT_BITS_DEF  = 24;

    // Fixed sizes of the sorted list and node identifiers.
    localparam int LIST_DEPTH = 256;
    localparam int LIST_IDX_W = 8;
    localparam int COUNT_W    = 9;
    localparam int NODE_ID_W  = 9;
    localparam int DEPTH_W    = 7;
    localparam logic [DEPTH_W-1:0] DEPTH_SAT = 7'd127;

    // Operation codes of an input transaction.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic        op;
        logic [7:0]  symbol;
        logic [23:0] weight;
        logic        last_load;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  code_symbol;
        logic [31:0] code_bits;
        logic [5:0]  code_length;
        logic        length_overflow;
    } t_out_item;

    // One sorted list entry: weight kept next to the node it belongs to.
    typedef struct packed {
        logic [31:0]          weight;
        logic [NODE_ID_W-1:0] node;
    } t_list_entry;

endpackage

FILE: src/huffman_code_table_builder.sv
// Top level of the Huffman code table builder. Depends on hctb_pkg and hctb_ram.
// Holds the sequencer, the valid bits and all table memories.
`timescale 1ns / 1ps
// A load transaction writes one symbol's frequency; a read transaction returns
// that symbol's code, length and overflow flag from the code memory, whose read
// data is registered, through the output register. A load marked last starts a
// build during which no transaction is accepted. The build scans the symbols,
// moves list entries during insertions, merges the two front entries of the
// sorted list memory and then walks the inner nodes of the code tree.
// Frequencies, codes and lengths read as zero after reset through valid bits,
// so no clearing pass is needed.
module huffman_code_table_builder
    import hctb_pkg::*;
#(
    parameter int ALPHABET     = ALPHABET_DEF,
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
    parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int SYM_W  = $clog2(ALPHABET);
    localparam int WALK_W = MAX_CODE_LEN + DEPTH_W;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_SCAN_RD, S_SCAN_CHK, S_INS_RD, S_INS_CMP,
        S_MRG_CHK, S_MRG_A, S_MRG_B, S_WALK0, S_WALK1, S_WK_RD, S_WK_L, S_WK_R
    } t_state;

    t_state                  r_state, n_state;
    logic                    r_out_valid, n_out_valid;
    t_out_item               r_out, n_out;
    logic [ALPHABET-1:0]     r_fvalid, n_fvalid;
    logic [ALPHABET-1:0]     r_cvalid, n_cvalid;
    logic [SYM_W-1:0]        r_sym, n_sym;
    logic [COUNT_W-1:0]      r_count, n_count;
    logic [LIST_IDX_W-1:0]   r_head, n_head;
    logic [NODE_ID_W-1:0]    r_next, n_next;
    logic [COUNT_W-1:0]      r_pos, n_pos;
    t_list_entry             r_ins, n_ins;
    logic                    r_merge, n_merge;
    t_list_entry             r_a, n_a;
    logic [NODE_ID_W-1:0]    r_node, n_node;
    logic [MAX_CODE_LEN-1:0] r_c, n_c;
    logic [DEPTH_W-1:0]      r_d, n_d;
    logic [NODE_ID_W-1:0]    r_rchild, n_rchild;
    logic [7:0]              r_rsym, n_rsym;
    logic                    r_rok, n_rok;

    // Memory ports.
    logic                    f_we;
    logic [SYM_W-1:0]        f_waddr, f_raddr;
    logic [WEIGHT_BITS-1:0]  f_wdata, f_rdata;
    logic                    l_we;
    logic [LIST_IDX_W-1:0]   l_waddr, l_raddr;
    t_list_entry             l_wdata, l_rdata;
    logic                    nd_we;
    logic [SYM_W-1:0]        nd_waddr, nd_raddr;
    logic [2*NODE_ID_W-1:0]  nd_wdata, nd_rdata;
    logic                    w_we;
    logic [SYM_W-1:0]        w_waddr, w_raddr;
    logic [WALK_W-1:0]       w_wdata, w_rdata;
    logic                    c_we;
    logic [SYM_W-1:0]        c_waddr;
    logic [WALK_W-1:0]       c_wdata, c_rdata;

    logic                    in_accept;
    logic                    sym_ok;
    logic [31:0]             w32;
    logic [32:0]             sum;
    logic [31:0]             sum_sat;
    logic [NODE_ID_W-1:0]    next_off, node_off;
    logic [NODE_ID_W-1:0]    place_child;
    logic [MAX_CODE_LEN-1:0] place_code;
    logic                    place_en;
    logic [MAX_CODE_LEN-1:0] wk_code;
    logic [DEPTH_W-1:0]      wk_depth;
    logic [DEPTH_W-1:0]      rd_len;
    logic [MAX_CODE_LEN-1:0] rd_code;
    logic                    ins_done;
    logic                    scan_next;
    logic [WEIGHT_BITS-1:0]  scan_w;

    hctb_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(ALPHABET)) u_freq (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_raddr(f_raddr), .o_rdata(f_rdata)
    );

    hctb_ram #(.WIDTH($bits(t_list_entry)), .DEPTH(LIST_DEPTH)) u_list (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(l_waddr), .i_wdata(l_wdata),
        .i_raddr(l_raddr), .o_rdata(l_rdata)
    );

    hctb_ram #(.WIDTH(2*NODE_ID_W), .DEPTH(ALPHABET)) u_node (
        .i_clk(i_clk), .i_we(nd_we), .i_waddr(nd_waddr), .i_wdata(nd_wdata),
        .i_raddr(nd_raddr), .o_rdata(nd_rdata)
    );

    hctb_ram #(.WIDTH(WALK_W), .DEPTH(ALPHABET)) u_walk (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    hctb_ram #(.WIDTH(WALK_W), .DEPTH(ALPHABET)) u_code (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_raddr(i_in_data.symbol[SYM_W-1:0]), .o_rdata(c_rdata)
    );

    // Handshake and fixed datapath terms.
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign sym_ok      = {1'b0, i_in_data.symbol} < NODE_ID_W'(ALPHABET);
    assign w32         = 32'(i_in_data.weight);
    assign sum         = {1'b0, r_a.weight} + {1'b0, l_rdata.weight};
    assign sum_sat     = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    assign next_off    = r_next - NODE_ID_W'(ALPHABET);
    assign node_off    = r_node - NODE_ID_W'(ALPHABET);
    assign wk_code     = w_rdata[WALK_W-1:DEPTH_W];
    assign wk_depth    = w_rdata[DEPTH_W-1:0];
    assign scan_w      = r_fvalid[r_sym] ? f_rdata : '0;

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_fvalid    = r_fvalid;
        n_cvalid    = r_cvalid;
        n_sym       = r_sym;
        n_count     = r_count;
        n_head      = r_head;
        n_next      = r_next;
        n_pos       = r_pos;
        n_ins       = r_ins;
        n_merge     = r_merge;
        n_a         = r_a;
        n_node      = r_node;
        n_c         = r_c;
        n_d         = r_d;
        n_rchild    = r_rchild;
        n_rsym      = r_rsym;
        n_rok       = r_rok;

        f_we        = 1'b0;
        f_waddr     = i_in_data.symbol[SYM_W-1:0];
        f_wdata     = w32[WEIGHT_BITS-1:0];
        f_raddr     = r_sym;
        l_we        = 1'b0;
        l_waddr     = r_head + r_pos[LIST_IDX_W-1:0];
        l_wdata     = r_ins;
        l_raddr     = r_head;
        nd_we       = 1'b0;
        nd_waddr    = next_off[SYM_W-1:0];
        nd_wdata    = {r_a.node, l_rdata.node};
        nd_raddr    = node_off[SYM_W-1:0];
        w_we        = 1'b0;
        w_waddr     = '0;
        w_wdata     = '0;
        w_raddr     = node_off[SYM_W-1:0];
        c_we        = 1'b0;
        c_waddr     = '0;
        c_wdata     = '0;
        place_en    = 1'b0;
        place_child = r_rchild;
        place_code  = {r_c[MAX_CODE_LEN-1:1], 1'b1};
        ins_done    = 1'b0;
        scan_next   = 1'b0;
        rd_len      = '0;
        rd_code     = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_in_data.op == OP_READ) begin
                        n_rsym  = i_in_data.symbol;
                        n_rok   = sym_ok;
                        n_state = S_READ;
                    end else begin
                        f_we = sym_ok;
                        if (sym_ok) begin
                            n_fvalid[i_in_data.symbol[SYM_W-1:0]] = 1'b1;
                        end
                        if (i_in_data.last_load) begin
                            n_cvalid = '0;
                            n_count  = '0;
                            n_head   = '0;
                            n_next   = NODE_ID_W'(ALPHABET);
                            n_sym    = '0;
                            n_merge  = 1'b0;
                            n_state  = S_SCAN_RD;
                        end
                    end
                end
            end
            // Code memory data is valid now; fill the output register.
            S_READ: begin
                if (r_rok && r_cvalid[r_rsym[SYM_W-1:0]]) begin
                    rd_len  = c_rdata[DEPTH_W-1:0];
                    rd_code = c_rdata[WALK_W-1:DEPTH_W];
                end
                n_out.code_symbol     = r_rsym;
                n_out.code_bits       = 32'(rd_code);
                n_out.length_overflow = rd_len > DEPTH_W'(MAX_CODE_LEN);
                n_out.code_length     = (rd_len > DEPTH_W'(MAX_CODE_LEN)) ?
                                        6'(MAX_CODE_LEN) : rd_len[5:0];
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end
            // Symbols with nonzero weight are inserted in symbol order.
            S_SCAN_CHK: begin
                if (scan_w != '0) begin
                    n_ins.weight = 32'(scan_w);
                    n_ins.node   = NODE_ID_W'(r_sym);
                    n_pos        = r_count;
                    n_state      = S_INS_RD;
                end else begin
                    scan_next = 1'b1;
                end
            end
            // Insertion walks from the tail, moving heavier entries up by one.
            S_INS_RD: begin
                if (r_pos == '0) begin
                    l_we     = 1'b1;
                    ins_done = 1'b1;
                end else begin
                    l_raddr = r_head + r_pos[LIST_IDX_W-1:0] - LIST_IDX_W'(1);
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                l_we = 1'b1;
                if (l_rdata.weight > r_ins.weight) begin
                    l_wdata = l_rdata;
                    n_pos   = r_pos - COUNT_W'(1);
                    n_state = S_INS_RD;
                end else begin
                    ins_done = 1'b1;
                end
            end
            S_MRG_CHK: begin
                if (r_count >= COUNT_W'(2)) begin
                    n_state = S_MRG_A;
                end else begin
                    n_state = S_WALK0;
                end
            end
            S_MRG_A: begin
                n_a     = l_rdata;
                l_raddr = r_head + LIST_IDX_W'(1);
                n_state = S_MRG_B;
            end
            // Pop the two front entries and insert their parent.
            S_MRG_B: begin
                nd_we        = 1'b1;
                n_head       = r_head + LIST_IDX_W'(2);
                n_count      = r_count - COUNT_W'(2);
                n_pos        = r_count - COUNT_W'(2);
                n_ins.weight = sum_sat;
                n_ins.node   = r_next;
                n_next       = r_next + NODE_ID_W'(1);
                n_merge      = 1'b1;
                n_state      = S_INS_RD;
            end
            S_WALK0: begin
                if (r_count == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_WALK1;
                end
            end
            // A single leaf root keeps every length at zero.
            S_WALK1: begin
                if (l_rdata.node < NODE_ID_W'(ALPHABET)) begin
                    n_state = S_IDLE;
                end else begin
                    place_child = l_rdata.node;
                    w_we        = 1'b1;
                    n_node      = r_next - NODE_ID_W'(1);
                    n_state     = S_WK_RD;
                end
            end
            S_WK_RD: begin
                if (r_node < NODE_ID_W'(ALPHABET)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_WK_L;
                end
            end
            // Children get the parent's code shifted left, depth plus one (saturating at DEPTH_SAT).
            S_WK_L: begin
                n_c         = {wk_code[MAX_CODE_LEN-2:0], 1'b0};
                n_d         = (wk_depth == DEPTH_SAT) ? DEPTH_SAT :
                              wk_depth + DEPTH_W'(1);
                n_rchild    = nd_rdata[NODE_ID_W-1:0];
                place_child = nd_rdata[2*NODE_ID_W-1:NODE_ID_W];
                place_code  = {wk_code[MAX_CODE_LEN-2:0], 1'b0};
                place_en    = 1'b1;
                n_state     = S_WK_R;
            end
            S_WK_R: begin
                place_en = 1'b1;
                n_node   = r_node - NODE_ID_W'(1);
                n_state  = S_WK_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Store addresses follow the child selected above.
        c_waddr = place_child[SYM_W-1:0];
        w_waddr = SYM_W'(place_child - NODE_ID_W'(ALPHABET));

        // Place a child: leaves go to the code table, inner nodes to the walk store.
        if (place_en) begin
            if (place_child < NODE_ID_W'(ALPHABET)) begin
                c_we     = 1'b1;
                c_wdata  = {place_code, n_d};
                n_cvalid[place_child[SYM_W-1:0]] = 1'b1;
            end else begin
                w_we    = 1'b1;
                w_wdata = {place_code, n_d};
            end
        end

        // Finishing an insertion returns to the merge loop or the scan.
        if (ins_done) begin
            n_count = r_count + COUNT_W'(1);
            if (r_merge) begin
                n_state = S_MRG_CHK;
            end else begin
                scan_next = 1'b1;
            end
        end
        if (scan_next) begin
            if (r_sym == SYM_W'(ALPHABET - 1)) begin
                n_state = S_MRG_CHK;
            end else begin
                n_sym   = r_sym + SYM_W'(1);
                n_state = S_SCAN_RD;
            end
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_fvalid    <= '0;
            r_cvalid    <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_fvalid    <= n_fvalid;
            r_cvalid    <= n_cvalid;
        end
        r_out    <= n_out;
        r_sym    <= n_sym;
        r_count  <= n_count;
        r_head   <= n_head;
        r_next   <= n_next;
        r_pos    <= n_pos;
        r_ins    <= n_ins;
        r_merge  <= n_merge;
        r_a      <= n_a;
        r_node   <= n_node;
        r_c      <= n_c;
        r_d      <= n_d;
        r_rchild <= n_rchild;
        r_rsym   <= n_rsym;
        r_rok    <= n_rok;
    end

endmodule

FILE: src/hctb_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps
module hctb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
